FILE: rtl/core/thermal_centroid_fall_detector_defines.svh
// Assertion macros for the thermal centroid fall detector.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef THERMAL_CENTROID_FALL_DETECTOR_DEFINES_SVH
`define THERMAL_CENTROID_FALL_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tcfd_pkg.sv
// Package for the thermal centroid fall detector.
// Holds frame geometry, field widths and derived constants; no dependencies.
`timescale 1ns / 1ps

package tcfd_pkg;

    localparam int FRAME_PIXELS = 64;
    localparam int ROW_WIDTH    = 8;

    localparam int PIX_W   = 12;
    localparam int HEAT_W  = 18;
    localparam int WSUM_W  = 21;
    localparam int CENT_W  = 11;
    localparam int DROP_W  = 12;
    localparam int LIMIT_W = 11;
    localparam int CFG_W   = 18;
    localparam int CFG_IDX_W = 2;

    localparam int IDX_W    = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int COL_W    = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
    localparam int LAST_ROW = (FRAME_PIXELS - 1) / ROW_WIDTH;
    localparam int ROW_W    = (LAST_ROW > 0) ? $clog2(LAST_ROW + 1) : 1;
    localparam int CMAX     = (LAST_ROW * 256 > 2047) ? 2047 : LAST_ROW * 256;

    localparam int WSUM_MAX = 2 ** (WSUM_W - 1) - 1;
    localparam int WSUM_MIN = -(2 ** (WSUM_W - 1));

    // Divider: non-negative weighted sum times 256 over a positive heat sum.
    localparam int QUO_W = WSUM_W - 1 + 8;
    localparam int DIV_W = HEAT_W - 1;
    localparam int CNT_W = $clog2(QUO_W);

    localparam logic [CFG_IDX_W-1:0] REG_HOT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEAT_SUM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 2'd3;

    localparam logic signed [PIX_W-1:0] RST_HOT_THRESHOLD = 12'sd108;
    localparam logic [HEAT_W-1:0]       RST_MIN_HEAT_SUM  = 18'd4;
    localparam logic [LIMIT_W-1:0]      RST_DROP_LIMIT    = 11'd358;
    localparam logic [LIMIT_W-1:0]      RST_UPPER_LIMIT   = 11'd1024;
    localparam logic [CENT_W-1:0]       RST_CENTROID      = 11'd896;

    typedef enum logic [3:0] {
        S_ACC   = 4'b0001,
        S_START = 4'b0010,
        S_DIV   = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

endpackage

FILE: rtl/core/tcfd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tcfd_pkg for the dividend, divisor and counter widths.
`timescale 1ns / 1ps

module tcfd_div import tcfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QUO_W-1:0]  i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quotient
);

    logic [QUO_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/thermal_centroid_fall_detector.sv
// Top level of the thermal centroid fall detector.
// Depends on tcfd_pkg, tcfd_div and thermal_centroid_fall_detector_defines.svh.
`timescale 1ns / 1ps
`include "thermal_centroid_fall_detector_defines.svh"

// Usage:
// Pixels of a frame enter in raster order on the input channel (i_in_valid,
// o_in_stall, i_pixel_temp), one item per cycle while a frame is streaming.
// Each pixel above the hot threshold is added to the heat sum and to the
// row-weighted sum in the cycle it is accepted.
// After the last pixel of a frame the input stalls while the centroid is
// computed by a restoring divider, one quotient bit per cycle.
// One result item per frame appears on the output channel (o_out_valid,
// i_out_stall), held in an output register; the next frame streams in while
// it waits.  If a result is still stalled when the next frame ends, the
// block holds that frame's result and keeps the input stalled until it moves.
// The registers are written through i_cfg_we, i_cfg_idx and i_cfg_data.
// Synchronous reset restores the register defaults, clears the sums and the
// pixel position, and sets the previous centroid to 3.5 rows.

module thermal_centroid_fall_detector import tcfd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [PIX_W-1:0]   i_pixel_temp,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [CENT_W-1:0]         o_centroid,
    output logic signed [DROP_W-1:0]  o_drop,
    output logic                      o_heat_present,
    output logic                      o_fall_detected,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int PROD_W = PIX_W + ROW_W + 1;
    localparam int SUM_W  = ((PROD_W > WSUM_W) ? PROD_W : WSUM_W) + 1;
    localparam logic signed [SUM_W-1:0] L_WMAX = SUM_W'(WSUM_MAX);
    localparam logic signed [SUM_W-1:0] L_WMIN = SUM_W'(WSUM_MIN);

    t_state r_state, n_state;

    logic signed [PIX_W-1:0]  r_hot_threshold;
    logic [HEAT_W-1:0]        r_min_heat_sum;
    logic [LIMIT_W-1:0]       r_drop_limit;
    logic [LIMIT_W-1:0]       r_upper_limit;

    logic [IDX_W-1:0]         r_pix_idx;
    logic [COL_W-1:0]         r_col;
    logic [ROW_W-1:0]         r_row;
    logic signed [HEAT_W-1:0] r_heat, n_heat;
    logic signed [WSUM_W-1:0] r_wsum, n_wsum;
    logic [CENT_W-1:0]        r_prev_centroid;

    logic                     r_out_valid;
    logic [CENT_W-1:0]        r_centroid;
    logic signed [DROP_W-1:0] r_drop;
    logic                     r_heat_present;
    logic                     r_fall_detected;

    logic                     in_accept;
    logic                     last_pixel;
    logic                     counts;
    logic signed [HEAT_W:0]   heat_add;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  wsum_add;

    logic                     div_start;
    logic                     div_done;
    logic [QUO_W-1:0]         div_dividend;
    logic [QUO_W-1:0]         div_quotient;

    logic                     present;
    logic                     out_free;
    logic                     out_load;
    logic [CENT_W-1:0]        cent_new;
    logic signed [DROP_W-1:0] drop_new;
    logic                     fall_new;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_ACC);
    assign last_pixel = (r_pix_idx == IDX_W'(FRAME_PIXELS - 1));
    assign counts     = i_pixel_temp > r_hot_threshold;

    // Saturating accumulation of one pixel.
    always_comb begin
        heat_add = {r_heat[HEAT_W-1], r_heat}
                 + {{(HEAT_W + 1 - PIX_W){i_pixel_temp[PIX_W-1]}}, i_pixel_temp};
        prod     = i_pixel_temp * $signed({1'b0, r_row});
        wsum_add = {{(SUM_W - WSUM_W){r_wsum[WSUM_W-1]}}, r_wsum}
                 + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
        if (heat_add[HEAT_W] != heat_add[HEAT_W-1]) begin
            n_heat = heat_add[HEAT_W] ? {1'b1, {(HEAT_W - 1){1'b0}}}
                                      : {1'b0, {(HEAT_W - 1){1'b1}}};
        end else begin
            n_heat = heat_add[HEAT_W-1:0];
        end
        if (wsum_add > L_WMAX) begin
            n_wsum = L_WMAX[WSUM_W-1:0];
        end else if (wsum_add < L_WMIN) begin
            n_wsum = L_WMIN[WSUM_W-1:0];
        end else begin
            n_wsum = wsum_add[WSUM_W-1:0];
        end
    end

    assign div_start    = (r_state == S_START);
    assign div_dividend = r_wsum[WSUM_W-1] ? '0 : {r_wsum[WSUM_W-2:0], 8'd0};

    tcfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_heat[DIV_W-1:0]),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Result of the finished frame.
    always_comb begin
        present  = !r_heat[HEAT_W-1] && (r_heat != '0)
                && ({1'b0, r_heat[HEAT_W-2:0]} >= r_min_heat_sum);
        cent_new = (div_quotient > QUO_W'(CMAX)) ? CENT_W'(CMAX)
                                                 : div_quotient[CENT_W-1:0];
        drop_new = $signed({1'b0, r_prev_centroid}) - $signed({1'b0, cent_new});
        fall_new = (drop_new > $signed({1'b0, r_drop_limit}))
                && (cent_new < r_upper_limit);
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_FIN) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACC:   if (in_accept && last_pixel) n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_ACC;
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_ACC;
            r_hot_threshold <= RST_HOT_THRESHOLD;
            r_min_heat_sum  <= RST_MIN_HEAT_SUM;
            r_drop_limit    <= RST_DROP_LIMIT;
            r_upper_limit   <= RST_UPPER_LIMIT;
            r_pix_idx       <= '0;
            r_col           <= '0;
            r_row           <= '0;
            r_heat          <= '0;
            r_wsum          <= '0;
            r_prev_centroid <= RST_CENTROID;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HOT_THRESHOLD: r_hot_threshold <= i_cfg_data[PIX_W-1:0];
                    REG_MIN_HEAT_SUM:  r_min_heat_sum  <= i_cfg_data[HEAT_W-1:0];
                    REG_DROP_LIMIT:    r_drop_limit    <= i_cfg_data[LIMIT_W-1:0];
                    REG_UPPER_LIMIT:   r_upper_limit   <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                if (counts) begin
                    r_heat <= n_heat;
                    r_wsum <= n_wsum;
                end
                if (last_pixel) begin
                    r_pix_idx <= '0;
                    r_col     <= '0;
                    r_row     <= '0;
                end else begin
                    r_pix_idx <= r_pix_idx + 1'b1;
                    if (r_col == COL_W'(ROW_WIDTH - 1)) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_heat      <= '0;
                r_wsum      <= '0;
                if (present) begin
                    r_prev_centroid <= cent_new;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_centroid      <= present ? cent_new : r_prev_centroid;
            r_drop          <= present ? drop_new : '0;
            r_heat_present  <= present;
            r_fall_detected <= present && fall_new;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_centroid      = r_centroid;
    assign o_drop          = r_drop;
    assign o_heat_present  = r_heat_present;
    assign o_fall_detected = r_fall_detected;

    `TCFD_ASSERT_NOW(a_fall_needs_heat, o_out_valid && o_fall_detected, o_heat_present,
        "fall flagged without heat present")
    `TCFD_ASSERT_NOW(a_no_heat_no_drop, o_out_valid && !o_heat_present, o_drop == '0,
        "nonzero drop on an ignored frame")
    `TCFD_ASSERT_NOW(a_centroid_range, o_out_valid, o_centroid <= CENT_W'(CMAX),
        "centroid above the last row")
    `TCFD_ASSERT_NEXT(a_frame_end_starts_div, in_accept && last_pixel,
        r_state == S_START && r_pix_idx == '0, "frame end did not start the divider")

endmodule
